/* rtl/life_grid_generation_assert.svh */
// Assertion macros used by the grid checker.
`ifndef LIFE_GRID_GENERATION_ASSERT_SVH
`define LIFE_GRID_GENERATION_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define LGG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LGG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid check failed");

`endif

/* rtl/lgg_pkg.sv */
// Shared types, widths and constants for the Life grid block.
package lgg_pkg;

	localparam int MAX_ROWS_DEF = 16;
	localparam int MAX_COLS_DEF = 16;

	// Count width: holds 0..127 for row and column counts
	localparam int CNT_W    = 7;
	localparam int CFG_W    = 5;
	localparam int REQ_W    = 2;
	localparam int POS_W    = 4;
	localparam int IDX_W    = 4;
	localparam int OUT_COLS = 16;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int NBR_W    = 4;

	localparam logic [CFG_W-1:0] CFG_RESET  = 5'd16;
	localparam logic [NBR_W-1:0] BIRTH_CNT  = 4'd3;
	localparam logic [NBR_W-1:0] KEEP_CNT   = 4'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_TOGGLE  = 2'd1,
		REQ_ADVANCE = 2'd2
	} req_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] rows;
		logic [CNT_W-1:0] cols;
	} lgg_dims_t;

endpackage

/* rtl/lgg_cfg_regs.sv */
// APB register file holding the grid size, with clamped effective counts.
module lgg_cfg_regs #(
	parameter int MAX_ROWS = lgg_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lgg_pkg::MAX_COLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lgg_pkg::APB_AW-1:0]   paddr,
	input  logic [lgg_pkg::APB_DW-1:0]   pwdata,
	output logic [lgg_pkg::APB_DW-1:0]   prdata,
	output lgg_pkg::lgg_dims_t           dims
);
	import lgg_pkg::*;

	localparam logic [CNT_W-1:0] ROWS_LIM = CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0] COLS_LIM = CNT_W'(MAX_COLS);

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic             wr_en;
	reg_idx_t         sel;

	// Zero counts as one, anything past the limit as the limit
	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CFG_W-1:0] raw,
			input logic [CNT_W-1:0] lim);
		logic [CNT_W-1:0] ext;
		ext = CNT_W'(raw);
		if (raw == '0) begin
			return CNT_W'(1);
		end else if (ext > lim) begin
			return lim;
		end
		return ext;
	endfunction

	assign sel   = reg_idx_t'(paddr[2]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_RESET;
			cols_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
				REG_COLS: cols_q <= pwdata[CFG_W-1:0];
				default:  rows_q <= rows_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_ROWS: prdata = APB_DW'(rows_q);
			REG_COLS: prdata = APB_DW'(cols_q);
			default:  prdata = '0;
		endcase
	end

	assign dims.rows = clamp_cnt(rows_q, ROWS_LIM);
	assign dims.cols = clamp_cnt(cols_q, COLS_LIM);

endmodule

/* rtl/lgg_row_cell.sv */
// One link of the row ring: holds a grid row and takes its neighbor's on a shift.
module lgg_row_cell #(
	parameter int COLS = lgg_pkg::MAX_COLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic [COLS-1:0] d,
	output logic [COLS-1:0] q
);
	import lgg_pkg::*;

	logic [COLS-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift) begin
			row_q <= d;
		end
	end

	assign q = row_q;

endmodule

/* rtl/lgg_row_rule.sv */
// B3/S23 rule applied to one row from the rows above and below it.
module lgg_row_rule #(
	parameter int COLS = lgg_pkg::MAX_COLS_DEF
) (
	input  logic [COLS-1:0] up,
	input  logic [COLS-1:0] mid,
	input  logic [COLS-1:0] dn,
	output logic [COLS-1:0] nxt
);
	import lgg_pkg::*;

	logic [COLS+1:0] up_p;
	logic [COLS+1:0] mid_p;
	logic [COLS+1:0] dn_p;

	// Pad one dead cell on each side; column c sits at padded index c+1
	assign up_p  = {1'b0, up, 1'b0};
	assign mid_p = {1'b0, mid, 1'b0};
	assign dn_p  = {1'b0, dn, 1'b0};

	always_comb begin
		logic [NBR_W-1:0] n;
		for (int c = 0; c < COLS; c++) begin
			n = NBR_W'(up_p[c]) + NBR_W'(up_p[c+1]) + NBR_W'(up_p[c+2])
				+ NBR_W'(mid_p[c]) + NBR_W'(mid_p[c+2])
				+ NBR_W'(dn_p[c]) + NBR_W'(dn_p[c+1]) + NBR_W'(dn_p[c+2]);
			nxt[c] = (n == BIRTH_CNT) || (mid[c] && (n == KEEP_CNT));
		end
	end

endmodule

/* rtl/life_grid_generation.sv */
// Top level of the Life grid block: row ring, rule, output register and config port.
// Conway's Life (birth on 3, survival on 2 or 3) on a grid of up to MAX_ROWS x MAX_COLS
// cells; rows_in_use and cols_in_use (APB, byte addresses 0 and 4) pick the part in use,
// with 0 taken as 1 and values past the maximum taken as the maximum. The grid lives in a
// ring of MAX_ROWS row cells. Every request (clear, toggle one cell, advance one
// generation; code 3 leaves the grid alone) makes exactly one trip around the ring, one row
// per cycle unless out_stall holds back a row in use: the row at the head is rewritten from
// itself, the row below it and a copy of the row that left the head on the previous shift,
// then goes back in at the tail and, if it is in use, is sent out as one item. The ring
// waits while an emitted row is stalled, and the next request is taken on the edge that
// ends the last step. Results come out row 0 upward, rows_in_use items per request,
// last_row marking the final one; columns past cols_in_use read as zero. Reset clears
// every cell at once, so there is no clearing pass.
module life_grid_generation #(
	parameter int MAX_ROWS = lgg_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lgg_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lgg_pkg::APB_AW-1:0]    paddr,
	input  logic [lgg_pkg::APB_DW-1:0]    pwdata,
	output logic [lgg_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lgg_pkg::REQ_W-1:0]     req_type,
	input  logic [lgg_pkg::POS_W-1:0]     cell_row,
	input  logic [lgg_pkg::POS_W-1:0]     cell_col,
	// row channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lgg_pkg::IDX_W-1:0]     row_index,
	output logic [lgg_pkg::OUT_COLS-1:0]  row_cells,
	output logic                          last_row
);
	import lgg_pkg::*;

	localparam int STEP_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int EXT_W  = (MAX_COLS > OUT_COLS) ? MAX_COLS : OUT_COLS;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_ROWS - 1);

	lgg_dims_t         dims;

	logic [MAX_COLS-1:0] chain [MAX_ROWS];
	logic [MAX_COLS-1:0] head;
	logic [MAX_COLS-1:0] below;
	logic [MAX_COLS-1:0] col_mask;
	logic [MAX_COLS-1:0] rule_up;
	logic [MAX_COLS-1:0] rule_mid;
	logic [MAX_COLS-1:0] rule_dn;
	logic [MAX_COLS-1:0] rule_nxt;
	logic [MAX_COLS-1:0] gen_row;
	logic [MAX_COLS-1:0] tog_mask;
	logic [MAX_COLS-1:0] feed;
	logic [MAX_COLS-1:0] emit;
	logic [EXT_W-1:0]    emit_ext;

	logic [CNT_W-1:0]    step_cnt;
	logic                row_live;
	logic                next_live;
	logic                is_last_row;
	logic                hit;
	logic                adv;
	logic                last_step;
	logic                accept;

	// control state
	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	// payload held for the request in flight and the ring
	logic [REQ_W-1:0]    req_q;
	logic [POS_W-1:0]    tgl_row_q;
	logic [POS_W-1:0]    tgl_col_q;
	logic [MAX_COLS-1:0] prev_q;

	// output register
	logic [IDX_W-1:0]    row_index_q;
	logic [OUT_COLS-1:0] row_cells_q;
	logic                last_row_q;

	lgg_cfg_regs #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.dims    (dims)
	);

	assign pready = 1'b1;

	// Row ring: each cell takes the next one's row, the tail takes the rewritten head
	for (genvar k = 0; k < MAX_ROWS; k++) begin : g_ring
		logic [MAX_COLS-1:0] cell_d;
		if (k == MAX_ROWS - 1) begin : g_tail
			assign cell_d = feed;
		end else begin : g_link
			assign cell_d = chain[k+1];
		end
		lgg_row_cell #(
			.COLS (MAX_COLS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (adv),
			.d      (cell_d),
			.q      (chain[k])
		);
	end

	assign head = chain[0];

	// A one-row grid has no row below the head
	if (MAX_ROWS > 1) begin : g_below
		assign below = chain[1];
	end else begin : g_no_below
		assign below = '0;
	end

	// Row position of the head and the columns in use
	assign step_cnt    = CNT_W'(step_q);
	assign row_live    = step_cnt < dims.rows;
	assign next_live   = (step_cnt + CNT_W'(1)) < dims.rows;
	assign is_last_row = (step_cnt + CNT_W'(1)) == dims.rows;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = CNT_W'(c) < dims.cols;
		end
	end

	// Neighbors outside the grid in use count as dead; row 0 has nothing above
	assign rule_up  = (step_q != '0) ? (prev_q & col_mask) : '0;
	assign rule_mid = head & col_mask;
	assign rule_dn  = next_live ? (below & col_mask) : '0;

	lgg_row_rule #(
		.COLS (MAX_COLS)
	) u_rule (
		.up  (rule_up),
		.mid (rule_mid),
		.dn  (rule_dn),
		.nxt (rule_nxt)
	);

	// A generation leaves every cell outside the grid in use dead
	assign gen_row = row_live ? (rule_nxt & col_mask) : '0;

	// Toggle only a cell inside the grid in use
	assign hit = (step_cnt == CNT_W'(tgl_row_q)) && row_live
		&& (CNT_W'(tgl_col_q) < dims.cols);
	assign tog_mask = hit ? (MAX_COLS'(1) << tgl_col_q) : '0;

	always_comb begin
		unique case (req_q)
			REQ_CLEAR:   feed = '0;
			REQ_TOGGLE:  feed = head ^ tog_mask;
			REQ_ADVANCE: feed = gen_row;
			default:     feed = head;
		endcase
	end

	assign emit     = feed & col_mask;
	assign emit_ext = EXT_W'(emit);

	// Turn the ring unless a row in use must go out while the output register is full and stalled
	assign adv       = busy_q && (!row_live || !out_valid_q || !out_stall);
	assign last_step = step_q == LAST_STEP;
	assign in_stall  = busy_q && !(adv && last_step);
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			// A new request starts its trip at row 0
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
			if (adv && row_live) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			tgl_row_q <= cell_row;
			tgl_col_q <= cell_col;
		end
		// Keep the old head: it is the row above the next head
		if (adv) begin
			prev_q <= head;
		end
		if (adv && row_live) begin
			row_index_q <= IDX_W'(step_q);
			row_cells_q <= emit_ext[OUT_COLS-1:0];
			last_row_q  <= is_last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_cells = row_cells_q;
	assign last_row  = last_row_q;

endmodule

/* rtl/lgg_chk.sv */
// Port-level checker for the Life grid block, bound to the top level.
`include "life_grid_generation_assert.svh"

module lgg_chk #(
	parameter int MAX_ROWS = lgg_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [lgg_pkg::IDX_W-1:0]     row_index,
	input  logic [lgg_pkg::OUT_COLS-1:0]  row_cells,
	input  logic                          last_row
);
	import lgg_pkg::*;

	// A stalled row stays offered
	`LGG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// A stalled row keeps its contents
	`LGG_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(row_index) && $stable(row_cells) && $stable(last_row))

	// A taken request keeps the channel closed while its rows go out
	`LGG_ASSERT_NEXT(a_busy_after_accept, (MAX_ROWS > 1) && in_valid && !in_stall, in_stall)

	// No new request while a dump is stuck mid-grid
	`LGG_ASSERT_NOW(a_no_overlap, out_valid && out_stall && !last_row, in_stall)

endmodule

bind life_grid_generation lgg_chk #(
	.MAX_ROWS (MAX_ROWS)
) u_lgg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row_index (row_index),
	.row_cells (row_cells),
	.last_row  (last_row)
);
